/* rtl/lz77s_pkg.sv */
`default_nettype none

package lz77s_pkg;

    // Sliding window depth and longest match
    localparam int WINDOW    = 256;
    localparam int MAX_MATCH = 255;

    // Scan lanes per cycle over the cell row
    localparam int LANES  = 16;
    localparam int LANE_W = 4;
    localparam int NGRP   = (WINDOW + LANES - 1) / LANES;
    localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int VEC_W  = NGRP * LANES;

    // Internal offset and length widths
    localparam int OFF_W = GRP_W + LANE_W + 1;
    localparam int LEN_W = $clog2(MAX_MATCH + 1);

    // Token field widths
    localparam int OFFSET_W = 9;
    localparam int LENGTH_W = 8;
    localparam int BYTE_W   = 8;
    localparam int TDATA_W  = 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_UPD
    } t_state;

    // Control broadcast along the cell row
    typedef struct packed {
        logic [BYTE_W-1:0] cmp_byte;
        logic              use_valid;
        logic              shift;
        logic              keep_live;
        logic              clear;
    } t_cell_ctl;

    // Nearest-offset results of one scan
    typedef struct packed {
        logic             hit_any;
        logic [OFF_W-1:0] hit_near;
        logic [OFF_W-1:0] live_near;
    } t_scan_res;

    // Lowest set bit of four: {any, index}
    function automatic logic [2:0] pe4(input logic [3:0] v);
        logic [2:0] r;
        r = 3'b000;
        for (int i = 3; i >= 0; i--) begin
            if (v[i]) begin
                r = {1'b1, 2'(i)};
            end
        end
        return r;
    endfunction

    // Lowest set bit of sixteen: {any, index}
    function automatic logic [LANE_W:0] pe16(input logic [LANES-1:0] v);
        logic [3:0] nib_any;
        logic [2:0] pick;
        logic [3:0] sel;
        logic [2:0] low;
        for (int i = 0; i < 4; i++) begin
            nib_any[i] = |v[4*i +: 4];
        end
        pick = pe4(nib_any);
        sel  = v[4*pick[1:0] +: 4];
        low  = pe4(sel);
        return {pick[2], pick[1:0], low[1:0]};
    endfunction

endpackage

`default_nettype wire

/* rtl/lz77s_cell.sv */
`default_nettype none

module lz77s_cell (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire lz77s_pkg::t_cell_ctl   i_ctl,
    input  wire logic [7:0]             i_prev_hist,
    input  wire logic                   i_prev_valid,
    output logic [7:0]                  o_hist,
    output logic                        o_valid,
    output logic                        o_hit
);
    import lz77s_pkg::*;

    logic [BYTE_W-1:0] r_hist;
    logic              r_valid;
    logic              r_live;
    logic              w_cand;

    // Compare this history byte against the incoming item
    assign w_cand = i_ctl.use_valid ? r_valid : r_live;
    assign o_hit  = w_cand && (r_hist == i_ctl.cmp_byte);

    // Shift history one place down the row
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_hist <= i_prev_hist;
        end
    end

    // Advance fill marker and live flag; drop both at message end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_live  <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_prev_valid && !i_ctl.clear;
            r_live  <= o_hit && i_ctl.keep_live && !i_ctl.clear;
        end
    end

    assign o_hist  = r_hist;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* rtl/lz77s_chain.sv */
`default_nettype none

module lz77s_chain (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lz77s_pkg::t_cell_ctl          i_ctl,
    output logic [lz77s_pkg::WINDOW-1:0]       o_hit_vec
);
    import lz77s_pkg::*;

    logic [BYTE_W-1:0] w_hist [WINDOW];
    logic [WINDOW-1:0] w_valid;

    // Cell g holds the byte g+1 places back
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        logic [BYTE_W-1:0] w_prev_hist;
        logic              w_prev_valid;

        if (g == 0) begin : g_head
            assign w_prev_hist  = i_ctl.cmp_byte;
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_hist  = w_hist[g-1];
            assign w_prev_valid = w_valid[g-1];
        end

        lz77s_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_prev_hist  (w_prev_hist),
            .i_prev_valid (w_prev_valid),
            .o_hist       (w_hist[g]),
            .o_valid      (w_valid[g]),
            .o_hit        (o_hit_vec[g])
        );
    end

endmodule

`default_nettype wire

/* rtl/lz77s_scan.sv */
`default_nettype none

module lz77s_scan (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic                          i_live_sel,
    input  wire logic [lz77s_pkg::WINDOW-1:0]  i_hit_vec,
    output logic                               o_busy,
    output lz77s_pkg::t_scan_res               o_res
);
    import lz77s_pkg::*;

    logic [VEC_W-1:0] r_hv;
    logic [GRP_W-1:0] r_grp;
    logic             r_busy;
    t_scan_res        r_res;
    logic [LANE_W:0]  w_pe;
    logic [OFF_W-1:0] w_near;

    // Encode the lowest hit in the current lane group
    assign w_pe   = pe16(r_hv[LANES-1:0]);
    assign w_near = OFF_W'({r_grp, w_pe[LANE_W-1:0]}) + OFF_W'(1);

    // Sequence the scan over the lane groups
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_grp  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_grp  <= '0;
        end else if (r_busy) begin
            r_grp <= r_grp + GRP_W'(1);
            if (r_grp == GRP_W'(NGRP - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Load the hit vector, then walk it one lane group a cycle; when i_live_sel
    // is set, the nearest live offset is the nearest hit of the previous item
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hv          <= VEC_W'(i_hit_vec);
            r_res.hit_any <= 1'b0;
            r_res.hit_near <= '0;
            if (i_live_sel) begin
                r_res.live_near <= r_res.hit_near;
            end
        end else if (r_busy) begin
            r_hv <= r_hv >> LANES;
            if (!r_res.hit_any && w_pe[LANE_W]) begin
                r_res.hit_any  <= 1'b1;
                r_res.hit_near <= w_near;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_res  = r_res;

endmodule

`default_nettype wire

/* rtl/lz77_stream_encoder.sv */
`default_nettype none

// LZ77 stream encoder, greedy, nearest match among equals.
// Input channel i_s_axis_*: one message byte per item, tlast on the final
// byte of a message. Output channel o_m_axis_*: one token per item holding
// offset, length, next literal and a has-next flag; tlast marks the final
// token of a message. A byte yields at most one token.
// Each accepted byte passes through the states S_LOAD, S_SCAN and S_UPD:
// S_LOAD compares the byte against every history cell at once, S_SCAN
// runs the nearest-offset scan, which walks the row 16 cells a cycle,
// and sees the scan finish, S_UPD shifts the history row and issues the
// token, and then S_IDLE accepts the next byte.
// Tokens sit in an output register; while the receiver stalls, the next
// byte is still accepted and worked on, and only the update that would
// issue a second token waits for the register to empty.
// Reset empties the history, drops every pending match and the held token.
// The history also clears after the last byte of each message.
module lz77_stream_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // data_byte [7:0]
    input  wire logic [7:0]  i_s_axis_tdata,
    input  wire logic        i_s_axis_tlast,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // match_offset [8:0], match_length [16:9], next_byte [24:17],
    // has_next [25], zero fill [31:26]
    output logic [31:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready
);
    import lz77s_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  n_len;
    logic              r_out_valid;
    logic [TDATA_W-1:0] r_out_data;
    logic              r_out_last;

    logic              w_accept;
    logic              w_load;
    logic              w_upd;
    logic              w_full;
    logic              w_emit;
    logic              w_advance;
    logic              w_keep;
    logic [OFF_W-1:0]  w_off;
    logic [LEN_W-1:0]  w_len;
    logic [BYTE_W-1:0] w_nb;
    logic              w_hn;
    logic              w_busy;
    logic [WINDOW-1:0] w_hit_vec;
    t_scan_res         w_res;
    t_cell_ctl         w_ctl;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full   = (r_len >= LEN_W'(MAX_MATCH));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_LOAD;
            S_LOAD: n_state = S_SCAN;
            S_SCAN: if (!w_busy) n_state = S_UPD;
            S_UPD:  if (w_advance) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_load          = 1'b0;
        w_upd           = 1'b0;
        unique case (r_state)
            S_IDLE:  o_s_axis_tready = 1'b1;
            S_LOAD:  w_load = 1'b1;
            S_SCAN:  ;
            S_UPD:   w_upd = 1'b1;
            default: ;
        endcase
    end

    // Decide the token and the next match length
    always_comb begin
        w_emit = 1'b0;
        w_keep = 1'b0;
        w_off  = '0;
        w_len  = r_len;
        w_nb   = r_byte;
        w_hn   = 1'b1;
        n_len  = '0;
        if (w_full) begin
            w_emit = 1'b1;
            w_off  = w_res.live_near;
        end else if (!w_res.hit_any) begin
            w_emit = 1'b1;
            w_off  = (r_len != '0) ? w_res.live_near : '0;
        end else begin
            w_keep = 1'b1;
            n_len  = r_len + LEN_W'(1);
            if (r_last) begin
                w_emit = 1'b1;
                w_off  = w_res.hit_near;
                w_len  = n_len;
                w_nb   = '0;
                w_hn   = 1'b0;
            end
        end
    end

    assign w_advance = !w_emit || !r_out_valid || i_m_axis_tready;

    // Broadcast control to the history row
    assign w_ctl.cmp_byte  = r_byte;
    assign w_ctl.use_valid = (r_len == '0);
    assign w_ctl.shift     = w_upd && w_advance;
    assign w_ctl.keep_live = w_keep;
    assign w_ctl.clear     = r_last;

    lz77s_chain u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .o_hit_vec (w_hit_vec)
    );

    lz77s_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_live_sel (r_len != '0),
        .i_hit_vec  (w_hit_vec),
        .o_busy     (w_busy),
        .o_res      (w_res)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            if (w_ctl.shift) begin
                r_len <= r_last ? '0 : n_len;
            end
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_s_axis_tdata;
            r_last <= i_s_axis_tlast;
        end
    end

    // Output register: fill on a token, drain on the receiver's ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.shift && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.shift && w_emit) begin
            r_out_data <= TDATA_W'({w_hn, w_nb, LENGTH_W'(w_len), OFFSET_W'(w_off)});
            r_out_last <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

/* rtl/lz77s_chk.sv */
`default_nettype none

module lz77s_chk (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        o_s_axis_tready,
    input  wire logic [31:0] o_m_axis_tdata,
    input  wire logic        o_m_axis_tlast,
    input  wire logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready
);

    // A stalled token stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("token dropped while stalled");

    // One byte in flight: ready drops after each accepted item
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second item accepted while busy");

    // A token without a next literal ends its message and carries zero
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[25]
            |-> o_m_axis_tlast && (o_m_axis_tdata[24:17] == 8'd0))
        else $error("token without next byte is malformed");

    // Offset zero only on a plain literal
    a_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[8:0] == 9'd0)
            |-> (o_m_axis_tdata[16:9] == 8'd0))
        else $error("match with zero offset");

endmodule

bind lz77_stream_encoder lz77s_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);

`default_nettype wire
